/* rtl/prc_pkg.sv */
`default_nettype none

package prc_pkg;

    // Element width that the test reads from the value field
    localparam int DATA_WIDTH = 32;
    // Row counter saturation point
    localparam int MAX_ROWS   = 128;

    // Fixed field widths of the stream ports
    localparam int VALUE_W    = 32;
    localparam int ROW_W      = 16;
    localparam int OUT_DATA_W = 56;

    // Divisor width: covers sqrt of the largest positive value plus a step
    localparam int DIV_W = DATA_WIDTH / 2 + 1;
    // Running square of the divisor, one bit of headroom above the value
    localparam int SQ_W  = DATA_WIDTH + 1;
    // Bit counter of the serial remainder unit
    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_ROWS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } t_rem_stat;

endpackage

`default_nettype wire

/* rtl/prc_rem_unit.sv */
`default_nettype none

module prc_rem_unit
    import prc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DATA_WIDTH-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]      i_divisor,
    output t_rem_stat                  o_stat
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_dvs;

    logic [DIV_W:0]        w_trial;
    logic [DIV_W:0]        w_diff;
    logic [DIV_W-1:0]      n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[DATA_WIDTH-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = w_diff[DIV_W-1:0];
        end else begin
            n_rem = w_trial[DIV_W-1:0];
        end
    end

    // Control: run one bit per cycle, pulse done after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands on start, then shift and reduce
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

    // A new request never lands on a running division
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    // Done follows the last bit step
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("remainder done without a running division");

endmodule

`default_nettype wire

/* rtl/prime_row_classifier.sv */
// Sequence: a value below 4, an even value or a negative value goes straight to the result state
// after acceptance. An odd value n >= 5 tries odd divisors d from 3 while d*d <= n; for each
// divisor a compare state is followed by a bit-serial division in the remainder unit, and a
// zero remainder ends the test as composite.
// Flow: one item at a time; the next is accepted once the result enters the output register.
// Reset: synchronous active-low i_rst_n clears sequencer, output valid and matrix state.
`default_nettype none

module prime_row_classifier
    import prc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // s_tdata: [31:0] value
    input  wire logic [VALUE_W-1:0]    i_s_tdata,
    // s_tlast: row_end
    input  wire logic                  i_s_tlast,
    // s_tuser: matrix_end
    input  wire logic                  i_s_tuser,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // m_tdata: [0] is_prime, [1] row_has_prime, [2] row_all_prime,
    //          [18:3] row_number, [50:19] largest_prime, [55:51] zero
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    // m_tlast: row_done
    output logic                       o_m_tlast,
    // m_tuser: matrix_done
    output logic                       o_m_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready
);

    t_state r_state;
    t_state n_state;

    // Item under test
    logic                          r_prime;
    logic                          n_prime;
    logic                          r_rend;
    logic                          r_mend;
    logic [DATA_WIDTH-1:0]         r_n;
    logic [DIV_W-1:0]              r_div;
    logic [DIV_W-1:0]              n_div;
    logic [SQ_W-1:0]               r_sq;
    logic [SQ_W-1:0]               n_sq;

    // Matrix and row state
    logic signed [DATA_WIDTH-1:0]  r_max;
    logic                          r_any;
    logic                          r_only;
    logic [ROW_W-1:0]              r_row;

    // Output register
    logic                          r_out_valid;
    logic [OUT_DATA_W-1:0]         r_out_data;
    logic                          r_out_last;
    logic                          r_out_user;

    logic signed [DATA_WIDTH-1:0]  w_val;
    logic                          w_accept;
    logic                          w_emit;
    logic                          w_start;
    logic                          w_any;
    logic                          w_only;
    logic signed [DATA_WIDTH-1:0]  w_max;
    logic signed [VALUE_W-1:0]     w_max_ext;
    t_rem_stat                     w_stat;

    assign w_val    = signed'(i_s_tdata[DATA_WIDTH-1:0]);
    assign w_accept = i_s_tvalid && (r_state == ST_IDLE);
    assign w_emit   = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    prc_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_n),
        .i_divisor  (r_div),
        .o_stat     (w_stat)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_val < 4 || !w_val[0]) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_sq > SQ_W'(r_n)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_stat.done) begin
                    if (w_stat.zero) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_DONE: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: divisor stepping and the primality verdict
    always_comb begin
        n_prime = r_prime;
        n_div   = r_div;
        n_sq    = r_sq;
        w_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_div   = DIV_W'(3);
                n_sq    = SQ_W'(9);
                n_prime = (w_val >= 2) && (w_val < 4);
            end
            ST_CHECK: begin
                if (r_sq > SQ_W'(r_n)) begin
                    n_prime = 1'b1;
                end else begin
                    w_start = 1'b1;
                end
            end
            ST_DIV: begin
                if (w_stat.done) begin
                    if (w_stat.zero) begin
                        n_prime = 1'b0;
                    end else begin
                        // (d+2)^2 = d^2 + 4d + 4
                        n_div = r_div + DIV_W'(2);
                        n_sq  = r_sq + SQ_W'({r_div, 2'b00}) + SQ_W'(4);
                    end
                end
            end
            ST_DONE: begin
                n_prime = r_prime;
            end
            default: begin
                n_prime = 1'b0;
            end
        endcase
    end

    // Row and matrix flags including the current item
    always_comb begin
        w_any  = r_any | r_prime;
        w_only = r_only & r_prime;
        w_max  = r_max;
        if (r_prime && (signed'(r_n) > r_max)) begin
            w_max = signed'(r_n);
        end
        w_max_ext = VALUE_W'(w_max);
    end

    // Control registers and matrix state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_max       <= '1;
            r_any       <= 1'b0;
            r_only      <= 1'b1;
            r_row       <= ROW_W'(1);
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_emit) begin
                if (r_mend) begin
                    r_max  <= '1;
                    r_any  <= 1'b0;
                    r_only <= 1'b1;
                    r_row  <= ROW_W'(1);
                end else begin
                    r_max <= w_max;
                    if (r_rend) begin
                        r_any  <= 1'b0;
                        r_only <= 1'b1;
                        if (r_row < ROW_LIMIT) begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_any  <= w_any;
                        r_only <= w_only;
                    end
                end
            end
        end
    end

    // Item payload and the output register
    always_ff @(posedge i_clk) begin
        r_prime <= n_prime;
        r_div   <= n_div;
        r_sq    <= n_sq;
        if (w_accept) begin
            r_n    <= DATA_WIDTH'(w_val);
            r_rend <= i_s_tlast;
            r_mend <= i_s_tuser;
        end
        if (w_emit) begin
            r_out_data <= {5'b0, w_max_ext, r_row, w_only, w_any, r_prime};
            r_out_last <= r_rend;
            r_out_user <= r_mend;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;
    assign o_m_tvalid = r_out_valid;

    // Running square tracks the divisor while testing
    a_square_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (64'(r_sq) == 64'(r_div) * 64'(r_div)))
        else $error("divisor square out of step");

    // Waiting on a division means the unit is running or just finished
    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (w_stat.busy || w_stat.done))
        else $error("sequencer waits on an idle remainder unit");

    // An all-prime flag never goes with a non-prime item, and a prime marks the row
    a_row_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((!o_m_tdata[2] || o_m_tdata[0]) && (!o_m_tdata[0] || o_m_tdata[1])))
        else $error("row flags disagree with item verdict");

endmodule

`default_nettype wire

/* tb/prime_row_checker.sv */
`default_nettype none

module prime_row_checker
    import prc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [VALUE_W-1:0]    i_s_tdata,
    input  wire logic                  i_s_tlast,
    input  wire logic                  i_s_tuser,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic                  i_m_tlast,
    input  wire logic                  i_m_tuser,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                     is_prime;
        logic                     row_done;
        logic                     row_has_prime;
        logic                     row_all_prime;
        logic [ROW_W-1:0]         row_number;
        logic signed [VALUE_W-1:0] largest_prime;
        logic                     matrix_done;
    } t_row_report;

    // Running matrix state of the predictor
    logic signed [VALUE_W-1:0] top_prime;
    logic                      row_any;
    logic                      row_only;
    int                        row_index;

    t_row_report expected_reports[$];
    int          fail_total;

    assign o_fail_count = fail_total;

    // Exact trial division over the sign-extended element
    function automatic bit is_prime_value(longint v);
        longint d;
        if (v < 2)
            return 1'b0;
        if (v < 4)
            return 1'b1;
        if (v[0] == 1'b0)
            return 1'b0;
        for (d = 3; d * d <= v; d += 2) begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_matrix();
        top_prime = -1;
        row_any   = 1'b0;
        row_only  = 1'b1;
        row_index = 1;
    endfunction

    // Classify one element, then advance the row and matrix state
    function automatic t_row_report classify_element(logic [VALUE_W-1:0] data,
                                                     logic rend, logic mend);
        t_row_report           rep;
        logic [DATA_WIDTH-1:0] low;
        longint                v;
        bit                    prime;
        low   = data[DATA_WIDTH-1:0];
        v     = longint'(signed'(low));
        prime = is_prime_value(v);
        if (prime) begin
            row_any = 1'b1;
            if (v > longint'(top_prime))
                top_prime = VALUE_W'(v);
        end else begin
            row_only = 1'b0;
        end
        rep.is_prime      = prime;
        rep.row_done      = rend;
        rep.row_has_prime = row_any;
        rep.row_all_prime = row_only;
        rep.row_number    = ROW_W'(row_index);
        rep.largest_prime = top_prime;
        rep.matrix_done   = mend;
        if (rend) begin
            row_any  = 1'b0;
            row_only = 1'b1;
            if (row_index < MAX_ROWS)
                row_index++;
        end
        if (mend)
            clear_matrix();
        return rep;
    endfunction

    function automatic void check_field(string name, longint expv, longint actv);
        if (expv != actv) begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            fail_total++;
        end
    endfunction

    initial begin
        fail_total = 0;
        o_pending  = 0;
        clear_matrix();
    end

    // Compare each result item first, then record the prediction for a new input item
    always @(posedge i_clk) begin
        t_row_report want;
        if (!i_rst_n) begin
            clear_matrix();
            expected_reports.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_total++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("is_prime", want.is_prime, i_m_tdata[0]);
                    check_field("row_has_prime", want.row_has_prime, i_m_tdata[1]);
                    check_field("row_all_prime", want.row_all_prime, i_m_tdata[2]);
                    check_field("row_number", want.row_number, i_m_tdata[18:3]);
                    check_field("largest_prime", want.largest_prime,
                                int'(signed'(i_m_tdata[50:19])));
                    check_field("pad", 0, i_m_tdata[55:51]);
                    check_field("row_done", want.row_done, i_m_tlast);
                    check_field("matrix_done", want.matrix_done, i_m_tuser);
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_reports.push_back(classify_element(i_s_tdata, i_s_tlast,
                                                            i_s_tuser));
        end
        o_pending <= expected_reports.size();
    end

endmodule

`default_nettype wire

/* tb/tb_prime_row_classifier.sv */
`default_nettype none

module tb_prime_row_classifier;
    import prc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Worst item is the largest positive prime
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int HOLD_CYCLES = 10_000;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic [VALUE_W-1:0]    i_s_tdata  = '0;
    logic                  i_s_tlast  = 1'b0;
    logic                  i_s_tuser  = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;
    logic                  o_m_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit idle_on     = 1'b0;
    bit hold_req    = 1'b0;

    prime_row_classifier u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    prime_row_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_s_tuser    (i_s_tuser),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_m_tuser    (o_m_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
                @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                i_m_tready <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one element, with an optional idle burst ahead of it
    task automatic send_element(logic [VALUE_W-1:0] value, logic rend, logic mend);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= value;
        i_s_tlast  <= rend;
        i_s_tuser  <= mend;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Hold the input idle until every expected result item is back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly cheap values; large ones are negative, even or multiples of three
    function automatic logic [VALUE_W-1:0] pick_element_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return VALUE_W'($urandom_range(0, 127));
        if (sel < 60)
            return VALUE_W'($urandom_range(0, 65535));
        if (sel < 70)
            return VALUE_W'($urandom_range(0, 1023));
        if (sel < 82)
            return {1'b1, 31'($urandom)};
        if (sel < 92)
            return {1'b0, 31'($urandom)} & ~32'd1;
        return VALUE_W'(3 * $urandom_range(1, 715827882));
    endfunction

    initial begin
        int i;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: edges of the value range, small cases, row and matrix ends
        idle_on = 1'b1;
        send_element(32'd0, 1'b0, 1'b0);
        send_element(32'd1, 1'b0, 1'b0);
        send_element(32'd2, 1'b0, 1'b0);
        send_element(32'd3, 1'b1, 1'b0);
        send_element(32'h8000_0000, 1'b0, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_element(32'd4, 1'b1, 1'b0);
        send_element(32'd97, 1'b0, 1'b0);
        send_element(32'd65521, 1'b0, 1'b0);
        send_element(32'd5, 1'b1, 1'b0);
        send_element(32'd9, 1'b0, 1'b0);
        send_element(32'd25, 1'b0, 1'b0);
        send_element(32'h7FFF_FFFE, 1'b1, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_element(32'd49, 1'b0, 1'b0);
        send_element(32'd121, 1'b0, 1'b0);
        send_element(32'd6, 1'b0, 1'b1);
        send_element(32'd7, 1'b1, 1'b0);
        send_element(32'd11, 1'b0, 1'b0);
        send_element(32'd15, 1'b0, 1'b1);
        drain_results();

        // Random matrices; long result hold-off first, idling off near the end
        idle_on  = 1'b1;
        hold_req = 1'b1;
        for (i = 0; i < 80; i++) begin
            if (i == 60)
                idle_on = 1'b0;
            send_element(pick_element_value(), $urandom_range(0, 3) == 0,
                         $urandom_range(0, 11) == 0);
        end
        drain_results();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/prc_pkg.sv
rtl/prc_rem_unit.sv
rtl/prime_row_classifier.sv
tb/prime_row_checker.sv
tb/tb_prime_row_classifier.sv
